FILE: src/pdws_pkg.sv
// Shared types and constants of the Poisson-disk window sampler.
`default_nettype none
package pdws_pkg;

   localparam int COORD_W    = 24;
   localparam int EXTENT_W   = 23;
   localparam int FRAC_W     = 16;
   localparam int DIST_W     = 49;
   localparam int WSIZE_W    = 7;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 49;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_X_LOW        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_EXTENT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOW        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_EXTENT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST_SQ  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_POINTS = 3'd6;

   // Register values after reset.
   localparam logic signed [COORD_W-1:0] RST_X_LOW        = -24'sd19200;
   localparam logic [EXTENT_W-1:0]       RST_X_EXTENT     = 23'd38400;
   localparam logic signed [COORD_W-1:0] RST_Y_LOW        = -24'sd19200;
   localparam logic [EXTENT_W-1:0]       RST_Y_EXTENT     = 23'd38400;
   localparam logic [DIST_W-1:0]         RST_MIN_DIST_SQ  = 49'd0;
   localparam logic [WSIZE_W-1:0]        RST_WINDOW_SIZE  = 7'd64;
   localparam logic [COUNT_W-1:0]        RST_TOTAL_POINTS = 16'd20;

   typedef struct packed {
      logic [FRAC_W-1:0] frac_x;
      logic [FRAC_W-1:0] frac_y;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [COUNT_W-1:0]        point_index;
      logic                      done_res;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   // Status from the distance unit: one compare finished, and whether it was too close.
   typedef struct packed {
      logic valid;
      logic near;
   } dist_res_type;

endpackage
`default_nettype wire

FILE: src/pdws_scale.sv
// Scales one random fraction into a saturated Q15.8 coordinate over two stages.
`default_nettype none
module pdws_scale (
   input  wire logic                                   clock,
   input  wire logic [pdws_pkg::FRAC_W-1:0]            frac,
   input  wire logic [pdws_pkg::EXTENT_W-1:0]          extent,
   input  wire logic signed [pdws_pkg::COORD_W-1:0]    low,
   output logic signed [pdws_pkg::COORD_W-1:0]         coord
);

   localparam int PROD_W = pdws_pkg::FRAC_W + pdws_pkg::EXTENT_W;
   localparam int SUM_W  = pdws_pkg::COORD_W + 1;

   logic [PROD_W-1:0]                      prod_ff;
   logic [PROD_W-1:0]                      prod_in;
   logic signed [pdws_pkg::COORD_W-1:0]    coord_ff;
   logic signed [pdws_pkg::COORD_W-1:0]    coord_in;
   logic signed [SUM_W-1:0]                sum;

   function automatic logic [pdws_pkg::EXTENT_W-1:0] prod_in_hi(input logic [PROD_W-1:0] p);
      return p[PROD_W-1:pdws_pkg::FRAC_W];
   endfunction

   assign prod_in = PROD_W'(frac) * PROD_W'(extent);

   always_comb begin
      sum = SUM_W'(low) + $signed({2'b00, prod_in_hi(prod_ff)});
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
         coord_in = sum[SUM_W-1] ? pdws_pkg::COORD_MIN : pdws_pkg::COORD_MAX;
      end else begin
         coord_in = sum[pdws_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      coord_ff <= coord_in;
   end

   assign coord = coord_ff;

endmodule
`default_nettype wire

FILE: src/pdws_window.sv
// Ring memory of recent accepted points with a registered read port.
`default_nettype none
module pdws_window #(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(WINDOW_MAX)-1:0]     wr_addr,
   input  wire pdws_pkg::point_type               wr_data,
   input  wire logic                              rd_en,
   input  wire logic [$clog2(WINDOW_MAX)-1:0]     rd_addr,
   output logic                                   rd_valid,
   output pdws_pkg::point_type                    rd_data
);

   localparam int SLOT_W = $clog2(WINDOW_MAX);

   pdws_pkg::point_type mem [WINDOW_MAX];
   pdws_pkg::point_type mem_q_ff;
   logic                rd_valid_ff;
   logic                seed_live_ff;
   logic                seed_live_in;
   logic                seed_hit_ff;

   // Slot zero holds the seed at the origin until it is first overwritten.
   assign seed_live_in = seed_live_ff && !(wr_en && wr_addr == '0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff    <= mem[rd_addr];
      seed_hit_ff <= seed_live_ff && (rd_addr == SLOT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         seed_live_ff <= 1'b1;
      end else begin
         rd_valid_ff  <= rd_en;
         seed_live_ff <= seed_live_in;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = seed_hit_ff ? '0 : mem_q_ff;

endmodule
`default_nettype wire

FILE: src/pdws_dist.sv
// Pipelined squared-distance unit: squares, then sum and threshold compare.
`default_nettype none
module pdws_dist (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire pdws_pkg::point_type         cand,
   input  wire pdws_pkg::point_type         point,
   input  wire logic [pdws_pkg::DIST_W-1:0] min_dist_sq,
   output pdws_pkg::dist_res_type           res
);

   localparam int DIFF_W = pdws_pkg::COORD_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;

   logic signed [DIFF_W-1:0]       dx;
   logic signed [DIFF_W-1:0]       dy;
   logic signed [SQ_W-1:0]         sqx_full;
   logic signed [SQ_W-1:0]         sqy_full;
   logic [pdws_pkg::DIST_W-1:0]    sqx_ff;
   logic [pdws_pkg::DIST_W-1:0]    sqy_ff;
   logic                           sq_valid_ff;
   logic [pdws_pkg::DIST_W:0]      sum;
   pdws_pkg::dist_res_type         res_ff;
   pdws_pkg::dist_res_type         res_in;

   assign dx       = DIFF_W'(cand.x) - DIFF_W'(point.x);
   assign dy       = DIFF_W'(cand.y) - DIFF_W'(point.y);
   assign sqx_full = dx * dx;
   assign sqy_full = dy * dy;

   // Each square is at most 2**48, so the low 49 bits hold it exactly.
   always_ff @(posedge clock) begin
      sqx_ff <= sqx_full[pdws_pkg::DIST_W-1:0];
      sqy_ff <= sqy_full[pdws_pkg::DIST_W-1:0];
   end

   assign sum          = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign res_in.valid = sq_valid_ff;
   assign res_in.near  = sq_valid_ff && (sum < {1'b0, min_dist_sq});

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         res_ff      <= '0;
      end else begin
         sq_valid_ff <= in_valid;
         res_ff      <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

FILE: src/poisson_disk_window_sampler.sv
// Top level of the Poisson-disk window sampler: sequencer, registers and result stage.
// Items are taken one at a time. A compared item scans the effective window (at most
// WINDOW_MAX) and then drains the memory read and the distance stages; an item rejected
// without comparison because the count is already reached skips the scan and the drain.
// A new item is taken only once the last one has its result; the single distance unit
// checks one stored point per cycle through the one read port of the ring memory.
// Reset (synchronous, active high) restores register defaults, the seed and a count of one.
`default_nettype none
module poisson_disk_window_sampler #(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pdws_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pdws_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pdws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pdws_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SLOT_W = $clog2(WINDOW_MAX);
   localparam int FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W  = pdws_pkg::COUNT_W;
   localparam logic [CNT_W-1:0] WMAX_CNT = CNT_W'(WINDOW_MAX);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCALE  = 3'd1;
   localparam logic [2:0] ST_PLACE  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   // Configuration registers.
   logic signed [pdws_pkg::COORD_W-1:0]  x_low_ff;
   logic [pdws_pkg::EXTENT_W-1:0]        x_extent_ff;
   logic signed [pdws_pkg::COORD_W-1:0]  y_low_ff;
   logic [pdws_pkg::EXTENT_W-1:0]        y_extent_ff;
   logic [pdws_pkg::DIST_W-1:0]          min_dist_sq_ff;
   logic [pdws_pkg::WSIZE_W-1:0]         window_size_ff;
   logic [CNT_W-1:0]                     total_points_ff;

   // Sequencer and sampler state.
   logic [2:0]          state_ff, state_in;
   pdws_pkg::req_type   req_ff;
   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]   rd_slot_ff, rd_slot_in;
   logic [FILL_W-1:0]   remain_ff, remain_in;
   logic [1:0]          drain_ff, drain_in;
   logic                open_ff, open_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pdws_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                csr_write;
   logic                out_free;
   logic                commit;
   logic                keep;
   logic [CNT_W-1:0]    win_a, win_b, win_c, win_d;
   logic [SLOT_W-1:0]   rd_addr;
   logic                rd_en;
   logic [SLOT_W-1:0]   next_slot;

   pdws_pkg::point_type     cand;
   pdws_pkg::point_type     stored;
   logic                    stored_valid;
   pdws_pkg::dist_res_type  dist_res;

   // ---------------------------------------------------------------------------------------
   // Configuration port. Writes are taken only while no item is in flight; an index beyond
   // the register list is accepted and dropped.
   // ---------------------------------------------------------------------------------------
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff        <= pdws_pkg::RST_X_LOW;
         x_extent_ff     <= pdws_pkg::RST_X_EXTENT;
         y_low_ff        <= pdws_pkg::RST_Y_LOW;
         y_extent_ff     <= pdws_pkg::RST_Y_EXTENT;
         min_dist_sq_ff  <= pdws_pkg::RST_MIN_DIST_SQ;
         window_size_ff  <= pdws_pkg::RST_WINDOW_SIZE;
         total_points_ff <= pdws_pkg::RST_TOTAL_POINTS;
      end else if (csr_write) begin
         unique case (csr_index)
            pdws_pkg::CSR_X_LOW: begin
               x_low_ff <= csr_data[pdws_pkg::COORD_W-1:0];
            end
            pdws_pkg::CSR_X_EXTENT: begin
               x_extent_ff <= csr_data[pdws_pkg::EXTENT_W-1:0];
            end
            pdws_pkg::CSR_Y_LOW: begin
               y_low_ff <= csr_data[pdws_pkg::COORD_W-1:0];
            end
            pdws_pkg::CSR_Y_EXTENT: begin
               y_extent_ff <= csr_data[pdws_pkg::EXTENT_W-1:0];
            end
            pdws_pkg::CSR_MIN_DIST_SQ: begin
               min_dist_sq_ff <= csr_data[pdws_pkg::DIST_W-1:0];
            end
            pdws_pkg::CSR_WINDOW_SIZE: begin
               window_size_ff <= csr_data[pdws_pkg::WSIZE_W-1:0];
            end
            pdws_pkg::CSR_TOTAL_POINTS: begin
               total_points_ff <= csr_data[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Datapath units. The scalers run two stages behind the captured fractions, so the
   // candidate is stable from the scan state onward.
   // ---------------------------------------------------------------------------------------
   pdws_scale u_scale_x (
      .clock  (clock),
      .frac   (req_ff.frac_x),
      .extent (x_extent_ff),
      .low    (x_low_ff),
      .coord  (cand.x)
   );

   pdws_scale u_scale_y (
      .clock  (clock),
      .frac   (req_ff.frac_y),
      .extent (y_extent_ff),
      .low    (y_low_ff),
      .coord  (cand.y)
   );

   pdws_window #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (commit && keep),
      .wr_addr  (write_slot_ff),
      .wr_data  (cand),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_valid (stored_valid),
      .rd_data  (stored)
   );

   pdws_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stored_valid),
      .cand        (cand),
      .point       (stored),
      .min_dist_sq (min_dist_sq_ff),
      .res         (dist_res)
   );

   // ---------------------------------------------------------------------------------------
   // Effective window: window_size, with zero standing for total_points, then clamped to
   // total_points, to the ring depth and to the number of points stored so far.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      win_a = (window_size_ff == '0) ? total_points_ff : CNT_W'(window_size_ff);
      win_b = (win_a > total_points_ff) ? total_points_ff : win_a;
      win_c = (win_b > WMAX_CNT) ? WMAX_CNT : win_b;
      win_d = (win_c > CNT_W'(fill_ff)) ? CNT_W'(fill_ff) : win_c;
   end

   // The scan walks backward from the newest point, one read per cycle.
   assign rd_addr   = (rd_slot_ff == '0) ? SLOT_W'(WINDOW_MAX - 1) : rd_slot_ff - 1'b1;
   assign rd_en     = (state_ff == ST_SCAN);
   assign next_slot = (32'(write_slot_ff) + 1 >= WINDOW_MAX) ? '0 : write_slot_ff + 1'b1;

   // A result may be written when the output register is empty or drains this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_DECIDE) && out_free;
   assign keep     = open_ff && !hit_ff;

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      rd_slot_in    = rd_slot_ff;
      remain_in     = remain_ff;
      drain_in      = drain_ff;
      open_in       = open_ff;
      hit_in        = hit_ff || (dist_res.valid && dist_res.near);
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            // Coordinates land at the end of this cycle; set up the scan meanwhile.
            open_in    = (count_ff < total_points_ff);
            hit_in     = 1'b0;
            remain_in  = FILL_W'(win_d);
            rd_slot_in = write_slot_ff;
            drain_in   = 2'd2;
            if ((count_ff < total_points_ff) && (win_d != '0)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_SCAN: begin
            rd_slot_in = rd_addr;
            remain_in  = remain_ff - 1'b1;
            if (remain_ff == FILL_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait for the memory read and the two distance stages to empty.
            drain_in = drain_ff - 1'b1;
            if (drain_ff == '0) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.accepted  = keep;
               rsp_data_in.point_x   = cand.x;
               rsp_data_in.point_y   = cand.y;
               rsp_data_in.point_index = keep ? count_ff : '0;
               if (keep) begin
                  write_slot_in = next_slot;
                  fill_in       = (32'(fill_ff) < WINDOW_MAX) ? fill_ff + 1'b1 : fill_ff;
                  count_in      = count_ff + 1'b1;
               end
               rsp_data_in.done_res = (count_in >= total_points_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= SLOT_W'(1);
         fill_ff       <= FILL_W'(1);
         count_ff      <= CNT_W'(1);
         rd_slot_ff    <= '0;
         remain_ff     <= '0;
         drain_ff      <= '0;
         open_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         rd_slot_ff    <= rd_slot_in;
         remain_ff     <= remain_in;
         drain_ff      <= drain_in;
         open_ff       <= open_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: the request beat is captured on acceptance, the result on commit.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: src/pdws_checker.sv
// Port-level checks of the sampler and the bind that attaches them.
`default_nettype none
module pdws_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire pdws_pkg::rsp_type                rsp_data,
   input wire logic                             csr_ready
);

   // A stalled result beat stays up with the same payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // One item at a time: after a beat is taken the input is stalled.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !csr_ready)
      else $error("input not held off after an accepted beat");

   // A rejected candidate carries index zero.
   a_reject_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> rsp_data.point_index == '0)
      else $error("rejected result with nonzero index");

   // The seed owns index zero, so a kept point never reports it.
   a_accept_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.point_index != '0)
      else $error("accepted result with index zero");

endmodule

bind poisson_disk_window_sampler pdws_checker u_pdws_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
`default_nettype wire

FILE: test/pdws_check_pkg.sv
// Point predictor and result scoreboard used by the sampler testbench.
package pdws_check_pkg;
   import pdws_pkg::*;

   localparam int WIN_MAX     = 64;
   localparam int MAX_REPORTS = 10;

   // An index past the last register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   class sample_checker;
      logic signed [COORD_W-1:0] x_low;
      logic [EXTENT_W-1:0]       x_extent;
      logic signed [COORD_W-1:0] y_low;
      logic [EXTENT_W-1:0]       y_extent;
      logic [DIST_W-1:0]         min_dist_sq;
      logic [WSIZE_W-1:0]        window_size;
      logic [COUNT_W-1:0]        total_points;

      point_type   ring[WIN_MAX];
      int unsigned write_slot;
      int unsigned window_fill;
      int unsigned accepted_count;

      rsp_type expected_verdicts[$];
      int      errors;

      function new();
         x_low          = RST_X_LOW;
         x_extent       = RST_X_EXTENT;
         y_low          = RST_Y_LOW;
         y_extent       = RST_Y_EXTENT;
         min_dist_sq    = RST_MIN_DIST_SQ;
         window_size    = RST_WINDOW_SIZE;
         total_points   = RST_TOTAL_POINTS;
         ring[0]        = '0;
         write_slot     = 1;
         window_fill    = 1;
         accepted_count = 1;
         errors         = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_X_LOW:        x_low        = val[COORD_W-1:0];
            CSR_X_EXTENT:     x_extent     = val[EXTENT_W-1:0];
            CSR_Y_LOW:        y_low        = val[COORD_W-1:0];
            CSR_Y_EXTENT:     y_extent     = val[EXTENT_W-1:0];
            CSR_MIN_DIST_SQ:  min_dist_sq  = val[DIST_W-1:0];
            CSR_WINDOW_SIZE:  window_size  = val[WSIZE_W-1:0];
            CSR_TOTAL_POINTS: total_points = val[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // low + floor(frac * extent / 2^16), clipped to the coordinate range.
      function longint place(logic signed [COORD_W-1:0] low, logic [EXTENT_W-1:0] extent,
                             logic [FRAC_W-1:0] frac);
         logic [63:0] prod;
         longint      c;
         prod = 64'(frac) * 64'(extent);
         c    = longint'(low) + longint'(prod >> FRAC_W);
         if (c > longint'(COORD_MAX)) c = longint'(COORD_MAX);
         if (c < longint'(COORD_MIN)) c = longint'(COORD_MIN);
         return c;
      endfunction

      function void note_candidate(req_type item);
         rsp_type     verdict;
         longint      cx, cy, dx, dy, gap_sq;
         int unsigned win, slot, index;
         logic        ok;
         cx    = place(x_low, x_extent, item.frac_x);
         cy    = place(y_low, y_extent, item.frac_y);
         ok    = (accepted_count < total_points);
         index = 0;
         if (ok) begin
            win = (window_size == 0) ? total_points : window_size;
            if (win > total_points) win = total_points;
            if (win > WIN_MAX) win = WIN_MAX;
            if (win > window_fill) win = window_fill;
            slot = write_slot;
            // Walk back from the newest point, stopping at the first one too close.
            for (int i = 0; i < win && ok; i++) begin
               slot   = (slot == 0) ? WIN_MAX - 1 : slot - 1;
               dx     = cx - ring[slot].x;
               dy     = cy - ring[slot].y;
               gap_sq = dx * dx + dy * dy;
               if (gap_sq < longint'(min_dist_sq)) ok = 1'b0;
            end
         end
         if (ok) begin
            ring[write_slot].x = cx[COORD_W-1:0];
            ring[write_slot].y = cy[COORD_W-1:0];
            write_slot = (write_slot + 1 >= WIN_MAX) ? 0 : write_slot + 1;
            if (window_fill < WIN_MAX) window_fill++;
            index          = accepted_count;
            accepted_count = (accepted_count + 1) & 16'hFFFF;
         end
         verdict.accepted    = ok;
         verdict.point_x     = cx[COORD_W-1:0];
         verdict.point_y     = cy[COORD_W-1:0];
         verdict.point_index = index[COUNT_W-1:0];
         verdict.done_res    = (accepted_count >= total_points);
         expected_verdicts.push_back(verdict);
      endfunction

      function string show(rsp_type r);
         return $sformatf("{acc %0b x %0d y %0d idx %0d done %0b}",
                          r.accepted, r.point_x, r.point_y, r.point_index, r.done_res);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("%s", msg);
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         if (expected_verdicts.size() == 0) begin
            flag($sformatf("%0t: result beat with nothing expected, got %s", $time, show(got)));
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.accepted !== want.accepted || got.point_x !== want.point_x ||
             got.point_y !== want.point_y || got.point_index !== want.point_index ||
             got.done_res !== want.done_res)
            flag($sformatf("%0t: mismatch, expected %s, got %s", $time, show(want), show(got)));
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      function void finish_check();
         if (expected_verdicts.size() != 0)
            flag($sformatf("%0d expected results never arrived", expected_verdicts.size()));
      endfunction
   endclass

endpackage

FILE: test/poisson_disk_window_sampler_tb.sv
// Self-checking testbench for the Poisson-disk window sampler top level.
module poisson_disk_window_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pdws_pkg::*;
   import pdws_check_pkg::*;

   // Sized from the slowest item, a scan of a full WIN_MAX window, so that
   // any stray result beat after the last expected one has come is seen.
   localparam int SETTLE_CYCLES  = 2 * (WIN_MAX + 7);
   // Cycles without any beat on any channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 400;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_RUNS
   } stall_mode_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   sample_checker verdicts = new();
   req_type       last_dart = '0;

   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    mode_left  = 0;
   int unsigned    run_left   = 0;

   poisson_disk_window_sampler #(
      .WINDOW_MAX(WIN_MAX)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Monitor. Every channel is sampled at the rising edge, before the block's
   // own updates land, so a beat is seen exactly when the block takes it. The
   // predictor is fed in acceptance order; register beats only arrive while
   // the block is idle, so their order against item beats is unambiguous.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) verdicts.check_verdict(rsp_data);
         if (req_valid && !req_stall) verdicts.note_candidate(req_data);
         if (csr_valid && csr_ready) verdicts.write_reg(csr_index, csr_data);
      end
   end

   // Receiver back-pressure. The pattern is redrawn on its own at random
   // times: no stall at all, sparse random stalls, mostly stalled, or long
   // alternating runs of stall and release. That way stalls land on every
   // phase of the block's compare loop and result stage.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left  <= 0;
         run_left   <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 256);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: begin
               if (run_left == 0) begin
                  rsp_stall <= ~rsp_stall;
                  run_left  <= $urandom_range(1, 24);
               end else begin
                  run_left <= run_left - 1;
               end
            end
         endcase
      end
   end

   // Watchdog: a correct run never goes this long without a beat anywhere.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("poisson_disk_window_sampler_tb: done, errors");
      $finish;
   end

   // Offer one item and hold it until the block takes it. Valid is left high
   // so that the next item of a burst can follow in the very next cycle.
   task automatic offer_candidate(logic [FRAC_W-1:0] fx, logic [FRAC_W-1:0] fy);
      req_valid      <= 1'b1;
      req_data.frac_x <= fx;
      req_data.frac_y <= fy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted result has been checked.
   // The check happens on the falling edge so it never races the monitor.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (verdicts.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // One register write; valid stays high so writes can go back to back.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Rewrite the whole register set, plus one write to the unused index that
   // the block has to ignore. Only called while nothing is in flight.
   task automatic configure(logic signed [COORD_W-1:0] xl, logic [EXTENT_W-1:0] xe,
                            logic signed [COORD_W-1:0] yl, logic [EXTENT_W-1:0] ye,
                            logic [DIST_W-1:0] md, logic [WSIZE_W-1:0] ws,
                            logic [COUNT_W-1:0] tp);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      write_csr(CSR_X_LOW, CSR_DATA_W'(xl));
      write_csr(CSR_X_EXTENT, CSR_DATA_W'(xe));
      write_csr(CSR_Y_LOW, CSR_DATA_W'(yl));
      write_csr(CSR_SPARE, noise[CSR_DATA_W-1:0]);
      write_csr(CSR_Y_EXTENT, CSR_DATA_W'(ye));
      write_csr(CSR_MIN_DIST_SQ, md);
      write_csr(CSR_WINDOW_SIZE, CSR_DATA_W'(ws));
      write_csr(CSR_TOTAL_POINTS, CSR_DATA_W'(tp));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [FRAC_W-1:0] corner_frac();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         default: return 16'h0001;
      endcase
   endfunction

   // Random fractions: mostly uniform, a quarter of them a small step away
   // from the previous dart so the distance test actually rejects some, and
   // the rest at the corners of the fraction range.
   function automatic req_type next_candidate();
      req_type     item;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
         item = req_type'($urandom);
      end else if (pick < 16) begin
         item.frac_x = last_dart.frac_x + FRAC_W'($urandom_range(0, 64) - 32);
         item.frac_y = last_dart.frac_y + FRAC_W'($urandom_range(0, 64) - 32);
      end else begin
         item.frac_x = corner_frac();
         item.frac_y = corner_frac();
      end
      last_dart = item;
      return item;
   endfunction

   // Send a number of random items in bursts with random gaps in between;
   // some bursts follow each other with no gap at all.
   task automatic throw_darts(int unsigned count);
      int unsigned left, burst, gap;
      req_type     item;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         if (burst > left) burst = left;
         left -= burst;
         repeat (burst) begin
            item = next_candidate();
            offer_candidate(item.frac_x, item.frac_y);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0 && left > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Rectangle edge and size: usually a modest box around the origin, now
   // and then the extremes of both registers or raw random bits.
   task automatic pick_rect(output logic signed [COORD_W-1:0] low,
                            output logic [EXTENT_W-1:0] extent);
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         low    = COORD_W'(20000 - int'($urandom_range(0, 40000)));
         extent = EXTENT_W'($urandom_range(0, 80000));
      end else if (pick < 17) begin
         case ($urandom_range(0, 2))
            0:       low = COORD_MIN;
            1:       low = COORD_MAX;
            default: low = '0;
         endcase
         extent = $urandom_range(0, 1) ? '1 : '0;
      end else begin
         low    = COORD_W'($urandom);
         extent = EXTENT_W'($urandom);
      end
   endtask

   // New register set for a random phase. The threshold is usually tied to
   // the box size so that both outcomes show up; the point limit is usually
   // wide open, sometimes just ahead of the current count so done is reached.
   task automatic shuffle_settings();
      logic signed [COORD_W-1:0] xl, yl;
      logic [EXTENT_W-1:0]       xe, ye;
      logic [DIST_W-1:0]         md;
      logic [WSIZE_W-1:0]        ws;
      logic [COUNT_W-1:0]        tp;
      logic [63:0]               noise;
      longint                    span, radius, target;
      int unsigned               pick;
      pick_rect(xl, xe);
      pick_rect(yl, ye);
      span   = (xe > ye) ? longint'(xe) : longint'(ye);
      radius = span * longint'($urandom_range(0, 24)) / 64;
      noise  = {$urandom, $urandom};
      pick   = $urandom_range(0, 19);
      if (pick < 2)      md = '0;
      else if (pick < 3) md = '1;
      else if (pick < 4) md = noise[DIST_W-1:0];
      else               md = DIST_W'(radius * radius);
      pick = $urandom_range(0, 19);
      if (pick < 14)      ws = WSIZE_W'($urandom_range(1, 64));
      else if (pick < 16) ws = '0;
      else if (pick < 18) ws = WSIZE_W'($urandom_range(65, 127));
      else                ws = $urandom_range(0, 1) ? WSIZE_W'(1) : WSIZE_W'(64);
      target = longint'(verdicts.accepted_count) + longint'($urandom_range(0, 30));
      if (target > 65535) target = 65535;
      pick = $urandom_range(0, 19);
      if (pick < 12)      tp = '1;
      else if (pick < 17) tp = COUNT_W'(target);
      else if (pick < 19) tp = COUNT_W'($urandom);
      else                tp = '0;
      configure(xl, xe, yl, ye, md, ws, tp);
   endtask

   initial begin : stimulus
      int unsigned random_items, batch;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, zero threshold: every dart is kept. The corners of
      // both fraction fields give the edges of the default box.
      offer_candidate(16'h0000, 16'h0000);
      offer_candidate(16'hFFFF, 16'hFFFF);
      offer_candidate(16'h0000, 16'hFFFF);
      offer_candidate(16'hFFFF, 16'h0000);
      offer_candidate(16'h8000, 16'h8000);
      drain();

      // Largest box pinned at the top of the x range, so x saturates; the
      // largest threshold rejects everything; a zero window size means the
      // window follows the point limit.
      configure(COORD_MAX, '1, COORD_MIN, '1, '1, '0, '1);
      offer_candidate(16'hFFFF, 16'hFFFF);
      offer_candidate(16'h0000, 16'h0000);
      offer_candidate(16'h1234, 16'hFFFF);
      drain();

      // Window of one: a repeat of the last point and a near miss are
      // rejected, while a point close to an older one gets through.
      configure(RST_X_LOW, RST_X_EXTENT, RST_Y_LOW, RST_Y_EXTENT, 49'd6553600,
                7'd1, '1);
      offer_candidate(16'h4000, 16'h4000);
      offer_candidate(16'h4000, 16'h4000);
      offer_candidate(16'h4010, 16'h4000);
      offer_candidate(16'hC000, 16'hC000);
      offer_candidate(16'h4000, 16'h4000);
      drain();

      // Point limit equal to the count already reached: rejected at once.
      configure(RST_X_LOW, RST_X_EXTENT, RST_Y_LOW, RST_Y_EXTENT, '0, RST_WINDOW_SIZE,
                COUNT_W'(verdicts.accepted_count));
      offer_candidate(16'h2222, 16'h3333);
      offer_candidate(16'hAAAA, 16'h5555);
      drain();

      // A point limit of zero also counts as done.
      configure(RST_X_LOW, RST_X_EXTENT, RST_Y_LOW, RST_Y_EXTENT, '0, RST_WINDOW_SIZE,
                '0);
      offer_candidate(16'h1111, 16'hEEEE);
      drain();

      // Room for exactly one more: it is kept and raises done in the same
      // result, and the next one is turned away.
      configure(RST_X_LOW, RST_X_EXTENT, RST_Y_LOW, RST_Y_EXTENT, '0, RST_WINDOW_SIZE,
                COUNT_W'(verdicts.accepted_count + 1));
      offer_candidate(16'h6666, 16'h9999);
      offer_candidate(16'h9999, 16'h6666);
      drain();

      // Zero-size box in a corner of the coordinate space and an oversized
      // window size: the first dart is kept, the identical second one is not.
      configure(COORD_MIN, '0, COORD_MAX, '0, 49'd1, 7'd127, '1);
      offer_candidate(16'hFFFF, 16'h0000);
      offer_candidate(16'h0000, 16'hFFFF);
      drain();

      // A squared distance exactly at the threshold is not too close.
      configure(RST_X_LOW, RST_X_EXTENT, RST_Y_LOW, RST_Y_EXTENT, 49'd22500, 7'd1, '1);
      offer_candidate(16'h0000, 16'h0000);
      offer_candidate(16'h0100, 16'h0000);
      offer_candidate(16'h0000, 16'h0000);
      drain();

      // Random phases, each with its own register set. Every phase ends by
      // draining the block, which is also where the sender holds off until
      // all expected results are in.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         shuffle_settings();
         batch = $urandom_range(8, 32);
         throw_darts(batch);
         drain();
         random_items += batch;
      end

      // Let the block sit for a while so a late stray beat would be caught.
      repeat (SETTLE_CYCLES) @(posedge clock);
      verdicts.finish_check();
      if (verdicts.errors == 0)
         $display("poisson_disk_window_sampler_tb: done, clean");
      else
         $display("poisson_disk_window_sampler_tb: done, errors");
      $finish;
   end

endmodule
